FILE: design/dlm_pkg.sv
package dlm_pkg;

  // Fixed widths of the transaction fields
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned FRAC_BITS   = 8;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_DIM    = 8;
  localparam int unsigned DEF_DATA_WIDTH = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_OUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE = 3'd4;

  typedef enum logic [1:0] {
    MODE_LOAD_X  = 2'd0,
    MODE_LOAD_W  = 2'd1,
    MODE_LOAD_B  = 2'd2,
    MODE_COMPUTE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    mode_e                     mode;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  // Datapath controls from the sequencer
  typedef struct packed {
    logic clear;     // zero the accumulator
    logic rd_valid;  // store read data is valid this cycle
    logic acc_en;    // product register is valid this cycle
    logic add_bias;  // add the bias entry when finishing
    logic relu;      // clamp negative results to zero
  } mac_ctrl_t;

  // Clamp a configured dimension into 1..maxd
  function automatic logic [DIM_W-1:0] dim_of(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxd);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxd) begin
      r = maxd;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/dlm_ram.sv
module dlm_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dlm_mac.sv
module dlm_mac import dlm_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_ctrl_t                    ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] w_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [VALUE_W-1:0]    result_o
);

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 4;

  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic signed [ACC_W-1:0]      acc_q, acc_d;
  logic signed [ACC_W-1:0]      sum;
  logic signed [ACC_W-1:0]      rounded;
  logic signed [ACC_W-1:0]      sat_hi;
  logic signed [ACC_W-1:0]      sat_lo;
  logic signed [DATA_WIDTH-1:0] sat;
  logic signed [DATA_WIDTH-1:0] act;
  logic signed [31:0]           act_ext;

  // Multiply the two store words
  always_comb begin
    prod_d = prod_q;
    if (ctrl_i.rd_valid) begin
      prod_d = x_i * w_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate products of one result element
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Add bias, round to Q8.8, saturate, apply activation
  always_comb begin
    sum = acc_q;
    if (ctrl_i.add_bias) begin
      sum = acc_q + (ACC_W'(b_i) <<< FRAC_BITS);
    end
    rounded = (sum + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    sat_hi  = ACC_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    sat_lo  = -sat_hi - ACC_W'(1);
    if (rounded > sat_hi) begin
      sat = sat_hi[DATA_WIDTH-1:0];
    end else if (rounded < sat_lo) begin
      sat = sat_lo[DATA_WIDTH-1:0];
    end else begin
      sat = rounded[DATA_WIDTH-1:0];
    end
    act = sat;
    if (ctrl_i.relu && sat[DATA_WIDTH-1]) begin
      act = '0;
    end
    act_ext  = 32'(act);
    result_o = act_ext[VALUE_W-1:0];
  end

endmodule

FILE: design/dense_layer_matmul_bias_relu.sv
// Dense layer: result = act(X * W + b) in signed Q8.8.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one
// transaction per item. Load items (mode 0, 1, 2) write one element of the
// input matrix, the weight matrix or the bias row.
// A compute item emits rows_in x cols_out result transactions on the output
// channel (out_valid_o / out_stall_i / out_data_o), row by row, with last
// set on the final element.
// For each result element the sequencer reads one input and one weight
// word per cycle through the single read port of each store into the one
// multiplier, drains the read, product and accumulator registers, then
// rounds the result and loads the output register. The input stalls for
// the run.
// A stalled receiver holds the output register; the sequencer waits in
// its finishing step until that register frees up. After the last element
// is loaded new items are accepted while it still waits.
// Reset restores the configuration registers and empties the output
// register; the stores are undefined until written.
module dense_layer_matmul_bias_relu import dlm_pkg::*; #(
  parameter int unsigned MAX_DIM    = DEF_MAX_DIM,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned BADR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned FULL_W = 2 * IDX_W + 1;

  // Configuration registers
  logic [DIM_W-1:0] rows_in_q, inner_size_q, cols_out_q;
  logic             act_mode_q, bias_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_q     <= DIM_W'(8);
      inner_size_q  <= DIM_W'(8);
      cols_out_q    <= DIM_W'(8);
      act_mode_q    <= 1'b0;
      bias_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_IN:     rows_in_q     <= cfg_wdata_i;
        CFG_INNER_SIZE:  inner_size_q  <= cfg_wdata_i;
        CFG_COLS_OUT:    cols_out_q    <= cfg_wdata_i;
        CFG_ACT_MODE:    act_mode_q    <= cfg_wdata_i[0];
        CFG_BIAS_ENABLE: bias_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] nr, nk, nc;
  assign nr = dim_of(rows_in_q, DIM_W'(MAX_DIM));
  assign nk = dim_of(inner_size_q, DIM_W'(MAX_DIM));
  assign nc = dim_of(cols_out_q, DIM_W'(MAX_DIM));

  // Sequencer state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, j_q, k_q;
  logic             rd_v_q, pr_v_q;
  out_item_t        out_q;
  logic             out_valid_q;

  logic in_acc, start, issue, out_load;
  logic k_last, i_last, j_last, el_last;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign k_last  = (DIM_W'(k_q) == nk - DIM_W'(1));
  assign i_last  = (DIM_W'(i_q) == nr - DIM_W'(1));
  assign j_last  = (DIM_W'(j_q) == nc - DIM_W'(1));
  assign el_last = i_last && j_last;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (k_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_q && !pr_v_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = el_last ? ST_IDLE : ST_RUN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_RUN:   issue      = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   out_load   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign start = in_acc && (in_data_i.mode == MODE_COMPUTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance element and inner indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      rd_v_q <= 1'b0;
      pr_v_q <= 1'b0;
    end else begin
      rd_v_q <= issue;
      pr_v_q <= rd_v_q;
      if (start) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (issue) begin
        k_q <= k_last ? '0 : k_q + IDX_W'(1);
      end else if (out_load && !el_last) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
    end
  end

  // Load decode
  logic                  ld_ok, x_we, w_we, b_we;
  logic [FULL_W-1:0]     ld_full;
  logic [ADDR_W-1:0]     ld_addr;
  logic signed [31:0]    ld_ext;
  logic [DATA_WIDTH-1:0] ld_data;

  assign ld_ok   = (DIM_W'(in_data_i.row) < DIM_W'(MAX_DIM))
                && (DIM_W'(in_data_i.col) < DIM_W'(MAX_DIM));
  assign x_we    = in_acc && (in_data_i.mode == MODE_LOAD_X) && ld_ok;
  assign w_we    = in_acc && (in_data_i.mode == MODE_LOAD_W) && ld_ok;
  assign b_we    = in_acc && (in_data_i.mode == MODE_LOAD_B)
                && (DIM_W'(in_data_i.col) < DIM_W'(MAX_DIM));
  assign ld_full = FULL_W'(in_data_i.row) * FULL_W'(MAX_DIM) + FULL_W'(in_data_i.col);
  assign ld_addr = ld_full[ADDR_W-1:0];
  assign ld_ext  = 32'(in_data_i.value);
  assign ld_data = ld_ext[DATA_WIDTH-1:0];

  // Read addresses for the current product
  logic [FULL_W-1:0] x_full, w_full;
  logic [ADDR_W-1:0] x_raddr, w_raddr;
  logic [BADR_W-1:0] b_raddr;

  assign x_full  = FULL_W'(i_q) * FULL_W'(MAX_DIM) + FULL_W'(k_q);
  assign w_full  = FULL_W'(k_q) * FULL_W'(MAX_DIM) + FULL_W'(j_q);
  assign x_raddr = x_full[ADDR_W-1:0];
  assign w_raddr = w_full[ADDR_W-1:0];
  assign b_raddr = j_q[BADR_W-1:0];

  logic [DATA_WIDTH-1:0] x_rdata, w_rdata, b_rdata;

  dlm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (ld_addr),
    .wdata_i (ld_data),
    .re_i    (issue),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  dlm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (ld_addr),
    .wdata_i (ld_data),
    .re_i    (issue),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dlm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DIM), .ADDR_W(BADR_W)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (in_data_i.col[BADR_W-1:0]),
    .wdata_i (ld_data),
    .re_i    (issue && (k_q == '0)),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Multiply-accumulate datapath
  mac_ctrl_t                 mac_ctrl;
  logic signed [VALUE_W-1:0] mac_result;

  assign mac_ctrl.clear    = start || (out_load && !el_last);
  assign mac_ctrl.rd_valid = rd_v_q;
  assign mac_ctrl.acc_en   = pr_v_q;
  assign mac_ctrl.add_bias = bias_enable_q;
  assign mac_ctrl.relu     = act_mode_q;

  dlm_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .x_i      (signed'(x_rdata)),
    .w_i      (signed'(w_rdata)),
    .b_i      (signed'(b_rdata)),
    .result_o (mac_result)
  );

  // Output register: load on finish, drop on transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_row   <= i_q;
      out_q.out_col   <= j_q;
      out_q.out_value <= mac_result;
      out_q.last      <= el_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reads stay inside the configured inner dimension
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (DIM_W'(k_q) < nk))
    else $error("inner index beyond inner_size");

  // Finishing only after the read and product registers drained
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (!rd_v_q && !pr_v_q))
    else $error("finish step with products in flight");

  // Element indexes stay inside the result matrix during a run
  a_ij_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> ((DIM_W'(i_q) < nr) && (DIM_W'(j_q) < nc)))
    else $error("element index beyond result matrix");

  // A loaded result with last set ends the run
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && el_last) |=> (state_q == ST_IDLE))
    else $error("run continued after last element");

endmodule
